[src/jsv_pkg.sv]
package jsv_pkg;

  // Width of the capacity register and of the output byte counter.
  localparam int CAP_W = 13;
  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  // Default build-time limit on the output buffer size.
  localparam int JSV_MAX_OUT_BYTES = 4096;

  // Depth of the queue between the classifier and the expander.
  localparam int JSV_QUEUE_DEPTH = 4;

  // Most bytes a single input byte can release: a lone high surrogate
  // (three bytes) followed by a three-byte code.
  localparam int REC_BYTES = 6;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_COLON  = 3'd1,
    ST_NO_QUOTE  = 3'd2,
    ST_EARLY_END = 3'd3,
    ST_TOO_LONG  = 3'd4
  } jsv_status_t;

  // Work for the expander: the data bytes first, then an optional status.
  typedef struct packed {
    logic [REC_BYTES-1:0][7:0] bytes;
    logic [2:0]                n_bytes;
    logic                      has_status;
    jsv_status_t               status;
  } jsv_rec_t;

endpackage

[src/jsv_queue.sv]
module jsv_queue
  import jsv_pkg::*;
#(
  parameter int DEPTH = JSV_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     wr,
  input  jsv_rec_t wr_data,
  input  logic     rd,
  output jsv_rec_t rd_data,
  output logic     q_full,
  output logic     q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  jsv_rec_t      slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign q_full  = (count == (AW+1)'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  // Storage for the waiting records.
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the depth; the count tells full from empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        count <= count + (AW+1)'(1);
      end else if (rd && !wr) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

endmodule

[src/jsv_front.sv]
module jsv_front
  import jsv_pkg::*;
#(
  parameter int MAX_OUT_BYTES = JSV_MAX_OUT_BYTES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_data,
  input  logic             take,
  input  logic [7:0]       in_byte,
  output logic             rec_valid,
  output jsv_rec_t         rec
);

  localparam int CapLimit = (MAX_OUT_BYTES > 8191) ? 8191 : MAX_OUT_BYTES;
  localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CapLimit);

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  typedef enum logic [6:0] {
    PH_COLON   = 7'b0000001,
    PH_QUOTE   = 7'b0000010,
    PH_BODY    = 7'b0000100,
    PH_ESC     = 7'b0001000,
    PH_HEX     = 7'b0010000,
    PH_PEND    = 7'b0100000,
    PH_PEND_BS = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } utf8_t;

  // UTF-8 encoding of one code point, first byte in slot 0.
  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t r;
    r.b = '0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.len  = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.len  = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.len  = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.len  = 3'd4;
    end
    return r;
  endfunction

  // Simple escapes; any other character stands for itself.
  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] d;
    case (c)
      8'h62:   d = 8'h08;
      8'h66:   d = 8'h0C;
      8'h6E:   d = 8'h0A;
      8'h72:   d = 8'h0D;
      8'h74:   d = 8'h09;
      default: d = c;
    endcase
    return d;
  endfunction

  phase_t           phase;
  logic [15:0]      hex_value;
  logic [2:0]       hex_count;
  logic             hex_stopped;
  logic [9:0]       pending_high;
  logic             has_pending;
  logic [CAP_W-1:0] bytes_used;
  logic [CAP_W-1:0] out_capacity;

  phase_t           phase_next;
  logic [15:0]      hex_value_next;
  logic [2:0]       hex_count_next;
  logic             hex_stopped_next;
  logic [9:0]       pending_high_next;
  logic             has_pending_next;
  logic [CAP_W-1:0] bytes_used_next;

  logic [CAP_W-1:0] cap_eff;
  logic             blank;
  logic [4:0]       hex_d;
  logic [15:0]      hex_new;
  logic             do_body;
  logic             do_esc;
  logic             rel;
  logic             sec_emit;
  logic [20:0]      sec_cp;
  logic             sec_st_v;
  jsv_status_t      sec_st;
  phase_t           sec_phase;
  logic             bad_phase;
  utf8_t            enc_a;
  utf8_t            enc_b;
  logic [CAP_W:0]   used_a;
  logic [CAP_W:0]   used_b;
  logic             fail_a;
  logic             fail_b;
  logic             a_out;
  logic             b_out;
  logic             ends;

  assign cap_eff = (out_capacity > CAP_LIMIT) ? CAP_LIMIT : out_capacity;
  assign blank   = (in_byte == 8'h20) || (in_byte == 8'h09) ||
                   (in_byte == 8'h0A) || (in_byte == 8'h0D);

  // Hex digit value; 16 marks a character that is not a digit.
  always_comb begin
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_d = 5'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_d = 5'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_d = 5'(in_byte - 8'h37);
    end else begin
      hex_d = 5'd16;
    end
    if (!hex_stopped && !hex_d[4]) begin
      hex_new = {hex_value[11:0], hex_d[3:0]};
    end else begin
      hex_new = hex_value;
    end
  end

  // Classify the byte: a possible release of a held high surrogate, then
  // one code to emit or one status that ends the value.
  always_comb begin
    hex_value_next    = hex_value;
    hex_count_next    = hex_count;
    hex_stopped_next  = hex_stopped;
    pending_high_next = pending_high;
    has_pending_next  = has_pending;
    do_body   = 1'b0;
    do_esc    = 1'b0;
    rel       = 1'b0;
    sec_emit  = 1'b0;
    sec_cp    = '0;
    sec_st_v  = 1'b0;
    sec_st    = ST_OK;
    sec_phase = phase;
    bad_phase = 1'b0;

    unique case (phase)
      PH_COLON: begin
        if (in_byte == CH_COLON) begin
          sec_phase = PH_QUOTE;
        end else if (!blank) begin
          sec_st_v = 1'b1;
          sec_st   = ST_NO_COLON;
        end
      end
      PH_QUOTE: begin
        if (in_byte == CH_QUOTE) begin
          sec_phase = PH_BODY;
        end else if (!blank) begin
          sec_st_v = 1'b1;
          sec_st   = ST_NO_QUOTE;
        end
      end
      PH_BODY: begin
        do_body = 1'b1;
      end
      PH_ESC: begin
        do_esc = 1'b1;
      end
      PH_HEX: begin
        if (in_byte == CH_END) begin
          sec_st_v = 1'b1;
          sec_st   = ST_EARLY_END;
        end else if (hex_count != 3'd3) begin
          hex_value_next   = hex_new;
          hex_count_next   = hex_count + 3'd1;
          hex_stopped_next = hex_stopped || hex_d[4];
        end else begin
          hex_value_next   = '0;
          hex_count_next   = '0;
          hex_stopped_next = 1'b0;
          if (has_pending && hex_new >= 16'hDC00 && hex_new <= 16'hDFFF) begin
            // Surrogate pair joined into one four-byte code.
            sec_emit          = 1'b1;
            sec_cp            = 21'h10000 + 21'({pending_high, hex_new[9:0]});
            pending_high_next = '0;
            has_pending_next  = 1'b0;
            sec_phase         = PH_BODY;
          end else begin
            if (has_pending) begin
              rel               = 1'b1;
              pending_high_next = '0;
              has_pending_next  = 1'b0;
            end
            if (hex_new >= 16'hD800 && hex_new <= 16'hDBFF) begin
              pending_high_next = hex_new[9:0];
              has_pending_next  = 1'b1;
              sec_phase         = PH_PEND;
            end else begin
              sec_emit  = 1'b1;
              sec_cp    = 21'(hex_new);
              sec_phase = PH_BODY;
            end
          end
        end
      end
      PH_PEND: begin
        if (in_byte == CH_BSL) begin
          sec_phase = PH_PEND_BS;
        end else begin
          rel               = 1'b1;
          pending_high_next = '0;
          has_pending_next  = 1'b0;
          do_body           = 1'b1;
        end
      end
      PH_PEND_BS: begin
        if (in_byte == CH_U) begin
          hex_value_next   = '0;
          hex_count_next   = '0;
          hex_stopped_next = 1'b0;
          sec_phase        = PH_HEX;
        end else begin
          rel               = 1'b1;
          pending_high_next = '0;
          has_pending_next  = 1'b0;
          do_esc            = 1'b1;
        end
      end
      default: begin
        bad_phase = 1'b1;
      end
    endcase

    // Plain string character.
    if (do_body) begin
      if (in_byte == CH_END) begin
        sec_st_v = 1'b1;
        sec_st   = ST_EARLY_END;
      end else if (in_byte == CH_QUOTE) begin
        sec_st_v = 1'b1;
        sec_st   = ST_OK;
      end else if (in_byte == CH_BSL) begin
        sec_phase = PH_ESC;
      end else begin
        sec_emit  = 1'b1;
        sec_cp    = 21'(in_byte);
        sec_phase = PH_BODY;
      end
    end

    // Character after a backslash.
    if (do_esc) begin
      if (in_byte == CH_END) begin
        sec_st_v = 1'b1;
        sec_st   = ST_EARLY_END;
      end else if (in_byte == CH_U) begin
        hex_value_next   = '0;
        hex_count_next   = '0;
        hex_stopped_next = 1'b0;
        sec_phase        = PH_HEX;
      end else begin
        sec_emit  = 1'b1;
        sec_cp    = 21'(esc_map(in_byte));
        sec_phase = PH_BODY;
      end
    end
  end

  // Capacity checks: the released surrogate first, then the main code.
  assign enc_a  = utf8_enc({5'b0, 6'b110110, pending_high});
  assign enc_b  = utf8_enc(sec_cp);
  assign used_a = {1'b0, bytes_used} + (rel ? (CAP_W+1)'(3) : '0);
  assign used_b = used_a + (CAP_W+1)'(enc_b.len);
  assign fail_a = rel && (used_a >= {1'b0, cap_eff});
  assign fail_b = !fail_a && sec_emit && (used_b >= {1'b0, cap_eff});
  assign a_out  = rel && !fail_a;
  assign b_out  = sec_emit && !fail_a && !fail_b;
  assign ends   = fail_a || fail_b || sec_st_v;

  // Record for the expander.
  always_comb begin
    rec.bytes = '0;
    if (a_out) begin
      rec.bytes[0] = enc_a.b[0];
      rec.bytes[1] = enc_a.b[1];
      rec.bytes[2] = enc_a.b[2];
      rec.bytes[3] = enc_b.b[0];
      rec.bytes[4] = enc_b.b[1];
      rec.bytes[5] = enc_b.b[2];
    end else begin
      rec.bytes[0] = enc_b.b[0];
      rec.bytes[1] = enc_b.b[1];
      rec.bytes[2] = enc_b.b[2];
      rec.bytes[3] = enc_b.b[3];
    end
    rec.n_bytes    = (a_out ? 3'd3 : 3'd0) + (b_out ? enc_b.len : 3'd0);
    rec.has_status = ends;
    rec.status     = (fail_a || fail_b) ? ST_TOO_LONG : sec_st;
    rec_valid      = take && (a_out || b_out || ends);
  end

  assign bytes_used_next = b_out ? used_b[CAP_W-1:0] : used_a[CAP_W-1:0];

  // Value state; an ended value or a bad phase clears everything.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COLON;
      hex_value    <= '0;
      hex_count    <= '0;
      hex_stopped  <= 1'b0;
      pending_high <= '0;
      has_pending  <= 1'b0;
      bytes_used   <= '0;
    end else if (take) begin
      if (ends || bad_phase) begin
        phase        <= PH_COLON;
        hex_value    <= '0;
        hex_count    <= '0;
        hex_stopped  <= 1'b0;
        pending_high <= '0;
        has_pending  <= 1'b0;
        bytes_used   <= '0;
      end else begin
        phase        <= sec_phase;
        hex_value    <= hex_value_next;
        hex_count    <= hex_count_next;
        hex_stopped  <= hex_stopped_next;
        pending_high <= pending_high_next;
        has_pending  <= has_pending_next;
        bytes_used   <= bytes_used_next;
      end
    end
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_we) begin
      out_capacity <= cfg_data;
    end
  end

endmodule

[src/jsv_back.sv]
module jsv_back
  import jsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  jsv_rec_t    head,
  output logic        q_rd,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte,
  output logic        is_status,
  output logic [2:0]  status,
  output logic        last_of_run
);

  logic       ovalid;
  logic [2:0] idx;
  logic [2:0] total;
  logic       load;
  logic       at_last;
  logic       at_status;

  assign total     = head.n_bytes + 3'(head.has_status);
  assign at_last   = (idx == total - 3'd1);
  assign at_status = (idx >= head.n_bytes);
  assign load      = !q_empty && (!ovalid || pop);
  assign q_rd      = load && at_last;
  assign empty     = !ovalid;

  // Walk through the head record, one result per cycle while the output register is empty or popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      idx    <= '0;
    end else begin
      if (load) begin
        ovalid <= 1'b1;
        idx    <= at_last ? 3'd0 : idx + 3'd1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
    end
  end

  // Output register holding the oldest waiting result.
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= at_status ? 8'h00 : head.bytes[idx];
      is_status   <= at_status;
      status      <= at_status ? head.status : ST_OK;
      last_of_run <= at_last;
    end
  end

endmodule

[src/json_string_value_decoder_top.sv]
// Path: the first result of an item passes through the queue slot and then the output register.
// Throughput: one item per cycle while each causes at most one result and the receiver pops; the
// single-byte result path sets the pace, so an item that causes several results holds it for each.
// Items causing no result (blanks, colon, quote, backslash, hex digits) do not enter the queue.
// Reset (rst, synchronous, active high) empties the queue and output register, returns the
// decoder to waiting for a colon and sets out_capacity to 4096.
module json_string_value_decoder_top
  import jsv_pkg::*;
#(
  parameter int MAX_OUT_BYTES = JSV_MAX_OUT_BYTES,
  parameter int QUEUE_DEPTH   = JSV_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       in_byte,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       out_byte,
  output logic             is_status,
  output logic [2:0]       status,
  output logic             last_of_run,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  logic     q_full;
  logic     q_empty;
  logic     q_rd;
  logic     take;
  logic     rec_valid;
  jsv_rec_t rec;
  jsv_rec_t head;

  assign full      = q_full;
  assign take      = push && !q_full;
  assign cfg_ready = 1'b1;

  // Classifier: parses the value and packs each byte's outcome.
  jsv_front #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .take      (take),
    .in_byte   (in_byte),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  // Short queue decoupling the classifier from the expander.
  jsv_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (rec_valid),
    .wr_data (rec),
    .rd      (q_rd),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Expander: one result item per cycle into the output register while it is empty or popped.
  jsv_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .head        (head),
    .q_rd        (q_rd),
    .pop         (pop),
    .empty       (empty),
    .out_byte    (out_byte),
    .is_status   (is_status),
    .status      (status),
    .last_of_run (last_of_run)
  );

endmodule

[sim/tb.sv]
module tb;
  import jsv_pkg::*;

  localparam int MAX_OUT = JSV_MAX_OUT_BYTES;
  localparam int LONG_HOLD = 150;
  localparam int PHASE_ITEMS = 58;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_END    = 8'h00;

  // Where the decoder stands within one value.
  typedef enum logic [3:0] {
    PH_COLON,
    PH_QUOTE,
    PH_BODY,
    PH_ESC,
    PH_HEX,
    PH_PEND,
    PH_PEND_BS
  } dec_phase_t;

  // One decoded item as it appears on the result ports.
  typedef struct packed {
    logic [7:0] data;
    logic       is_st;
    logic [2:0] st;
    logic       last;
  } dec_item_t;

  // One row of the directed table; typed rows carry their own expected item.
  typedef struct packed {
    logic [7:0] c;
    logic       typed;
    dec_item_t  want;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             push;
  logic             full;
  logic [7:0]       in_byte;
  logic             empty;
  logic             pop;
  logic [7:0]       out_byte;
  logic             is_status;
  logic [2:0]       status;
  logic             last_of_run;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;

  json_string_value_decoder_top DUT (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_byte    (in_byte),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .is_status  (is_status),
    .status     (status),
    .last_of_run(last_of_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Decoder state as predicted by the testbench.
  dec_phase_t       dec_phase;
  logic [15:0]      hex_val;
  logic [2:0]       hex_cnt;
  logic             hex_stop;
  logic [9:0]       high_part;
  logic             high_held;
  logic [CAP_W-1:0] used;
  logic [CAP_W-1:0] cap_reg;

  dec_item_t step_items[$];
  dec_item_t decoded_q[$];
  logic [7:0] text_q[$];
  dir_row_t dir_tab[$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_req = 1'b0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Value of a hex digit, or 16 for any other character.
  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return 16;
  endfunction

  function automatic void put_item(input logic [7:0] b, input logic is_st,
                                   input logic [2:0] st);
    dec_item_t it;
    it.data = b;
    it.is_st = is_st;
    it.st = st;
    it.last = 1'b0;
    step_items.push_back(it);
  endfunction

  function automatic void clear_value();
    dec_phase = PH_COLON;
    hex_val = '0;
    hex_cnt = '0;
    hex_stop = 1'b0;
    high_part = '0;
    high_held = 1'b0;
    used = '0;
  endfunction

  function automatic void finish_value(input logic [2:0] st);
    put_item(8'h00, 1'b1, st);
    clear_value();
  endfunction

  // Encode one code point as UTF-8 if it fits; otherwise end the value as too long.
  function automatic bit emit_code(input logic [20:0] cp);
    logic [7:0] enc [0:3];
    int n;
    int lim;
    lim = (cap_reg > MAX_OUT) ? MAX_OUT : int'(cap_reg);
    if (cp < 21'h80) begin
      enc[0] = cp[7:0];
      n = 1;
    end else if (cp < 21'h800) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      n = 2;
    end else if (cp < 21'h10000) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      n = 3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      n = 4;
    end
    if (int'(used) + n >= lim) begin
      finish_value(ST_TOO_LONG);
      return 1'b0;
    end
    for (int i = 0; i < n; i++) put_item(enc[i], 1'b0, ST_OK);
    used = used + n;
    return 1'b1;
  endfunction

  // A held high surrogate goes out on its own as a three-byte code.
  function automatic bit release_high();
    logic [20:0] cp;
    cp = {5'd0, 6'b110110, high_part};
    high_held = 1'b0;
    high_part = '0;
    return emit_code(cp);
  endfunction

  function automatic void do_body(input logic [7:0] c);
    if (c == CH_END) finish_value(ST_EARLY_END);
    else if (c == CH_QUOTE) finish_value(ST_OK);
    else if (c == CH_BSLASH) dec_phase = PH_ESC;
    else void'(emit_code({13'd0, c}));
  endfunction

  function automatic void start_hex();
    hex_val = '0;
    hex_cnt = '0;
    hex_stop = 1'b0;
    dec_phase = PH_HEX;
  endfunction

  function automatic void do_esc(input logic [7:0] c);
    logic [7:0] d;
    if (c == CH_END) begin
      finish_value(ST_EARLY_END);
      return;
    end
    if (c == "u") begin
      start_hex();
      return;
    end
    case (c)
      "b": d = 8'h08;
      "f": d = 8'h0C;
      "n": d = 8'h0A;
      "r": d = 8'h0D;
      "t": d = 8'h09;
      default: d = c;
    endcase
    dec_phase = PH_BODY;
    void'(emit_code({13'd0, d}));
  endfunction

  // A complete escape code either starts a surrogate pair or goes out at once.
  function automatic void fresh_code(input logic [15:0] cp);
    if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
      high_part = cp[9:0];
      high_held = 1'b1;
      dec_phase = PH_PEND;
    end else begin
      dec_phase = PH_BODY;
      void'(emit_code({5'd0, cp}));
    end
  endfunction

  function automatic void do_hex(input logic [7:0] c);
    int d;
    logic [15:0] cp;
    if (c == CH_END) begin
      finish_value(ST_EARLY_END);
      return;
    end
    d = hex_digit(c);
    // The first non-hex character freezes the value; the rest of the four are eaten.
    if (!hex_stop && d < 16) hex_val = {hex_val[11:0], 4'(d)};
    else hex_stop = 1'b1;
    hex_cnt = hex_cnt + 1'b1;
    if (hex_cnt < 3'd4) return;
    cp = hex_val;
    hex_val = '0;
    hex_cnt = '0;
    hex_stop = 1'b0;
    if (high_held) begin
      if (cp >= 16'hDC00 && cp <= 16'hDFFF) begin
        high_held = 1'b0;
        dec_phase = PH_BODY;
        void'(emit_code(21'h10000 + {1'b0, high_part, cp[9:0]}));
        high_part = '0;
        return;
      end
      if (!release_high()) return;
    end
    fresh_code(cp);
  endfunction

  // Predict every result caused by one input byte into step_items.
  function automatic void decode_byte(input logic [7:0] c);
    bit blank;
    step_items.delete();
    blank = (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D);
    case (dec_phase)
      PH_COLON: begin
        if (c == CH_COLON) dec_phase = PH_QUOTE;
        else if (!blank) finish_value(ST_NO_COLON);
      end
      PH_QUOTE: begin
        if (c == CH_QUOTE) dec_phase = PH_BODY;
        else if (!blank) finish_value(ST_NO_QUOTE);
      end
      PH_BODY: do_body(c);
      PH_ESC: do_esc(c);
      PH_HEX: do_hex(c);
      PH_PEND: begin
        if (c == CH_BSLASH) begin
          dec_phase = PH_PEND_BS;
        end else if (release_high()) begin
          dec_phase = PH_BODY;
          do_body(c);
        end
      end
      PH_PEND_BS: begin
        if (c == "u") start_hex();
        else if (release_high()) do_esc(c);
      end
      default: clear_value();
    endcase
    if (step_items.size() > 0) step_items[step_items.size() - 1].last = 1'b1;
  endfunction

  function automatic void row(input logic [7:0] c, input bit typed = 1'b0,
                              input logic [7:0] b = 8'h00, input bit st_flag = 1'b0,
                              input logic [2:0] st = ST_OK);
    dir_row_t r;
    r.c = c;
    r.typed = typed;
    r.want.data = b;
    r.want.is_st = st_flag;
    r.want.st = st;
    r.want.last = 1'b1;
    dir_tab.push_back(r);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + n;
    return ($urandom_range(1) ? 8'h41 : 8'h61) + n - 8'd10;
  endfunction

  function automatic void add_hex4(input logic [15:0] v);
    for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  function automatic void add_blanks();
    int n;
    n = $urandom_range(2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: text_q.push_back(8'h20);
        1: text_q.push_back(8'h09);
        2: text_q.push_back(8'h0A);
        default: text_q.push_back(8'h0D);
      endcase
    end
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  // Build one value into text_q: mostly well formed with random content,
  // sometimes noise or a value broken in the prefix, escape or hex digits.
  function automatic void build_value();
    int r;
    int kind;
    int k;
    logic [7:0] c;
    text_q.delete();
    r = $urandom_range(99);
    if (r < 5) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) text_q.push_back(8'($urandom_range(255)));
      return;
    end
    add_blanks();
    if (r < 9) text_q.push_back(8'($urandom_range(255)));
    text_q.push_back(CH_COLON);
    add_blanks();
    if (r < 13) text_q.push_back(8'($urandom_range(255)));
    else text_q.push_back(CH_QUOTE);
    k = $urandom_range(6);
    for (int t = 0; t < k; t++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        text_q.push_back(plain_char());
      end else if (kind < 50) begin
        text_q.push_back(CH_BSLASH);
        case ($urandom_range(7))
          0: text_q.push_back("b");
          1: text_q.push_back("f");
          2: text_q.push_back("n");
          3: text_q.push_back("r");
          4: text_q.push_back("t");
          5: text_q.push_back(CH_QUOTE);
          6: text_q.push_back(CH_BSLASH);
          default: text_q.push_back("/");
        endcase
      end else if (kind < 58) begin
        // Escape with a random character: most stand for themselves, but b, f, n, r, t and u keep their meaning.
        text_q.push_back(CH_BSLASH);
        text_q.push_back(plain_char());
      end else if (kind < 72) begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back("u");
        case ($urandom_range(3))
          0: add_hex4(16'($urandom_range(16'h7F)));
          1: add_hex4(16'($urandom_range(16'h80, 16'h7FF)));
          2: add_hex4(16'($urandom_range(16'hFFFF)));
          default: add_hex4(16'($urandom_range(16'hE000, 16'hFFFF)));
        endcase
      end else if (kind < 84) begin
        // Surrogate pair joined into one four-byte code.
        text_q.push_back(CH_BSLASH);
        text_q.push_back("u");
        add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
        text_q.push_back(CH_BSLASH);
        text_q.push_back("u");
        add_hex4(16'($urandom_range(16'hDC00, 16'hDFFF)));
      end else if (kind < 92) begin
        // Lone high surrogate; whatever token follows decides its fate.
        text_q.push_back(CH_BSLASH);
        text_q.push_back("u");
        add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
      end else if (kind < 96) begin
        // Hex run cut short by a non-hex character.
        text_q.push_back(CH_BSLASH);
        text_q.push_back("u");
        r = $urandom_range(3);
        for (int i = 0; i < r; i++) text_q.push_back(hex_char(4'($urandom_range(15))));
        do c = 8'($urandom_range(1, 255)); while (hex_digit(c) < 16);
        text_q.push_back(c);
        for (int i = r + 1; i < 4; i++) text_q.push_back(8'($urandom_range(1, 255)));
      end else begin
        // End byte inside an escape or inside the hex digits.
        text_q.push_back(CH_BSLASH);
        case ($urandom_range(2))
          0: ;
          1: begin
            text_q.push_back("u");
            r = $urandom_range(3);
            for (int i = 0; i < r; i++) text_q.push_back(hex_char(4'($urandom_range(15))));
          end
          default: begin
            text_q.push_back("u");
            add_hex4(16'($urandom_range(16'hD800, 16'hDBFF)));
            text_q.push_back(CH_BSLASH);
          end
        endcase
        text_q.push_back(CH_END);
        return;
      end
    end
    if ($urandom_range(99) < 6) text_q.push_back(CH_END);
    else text_q.push_back(CH_QUOTE);
  endfunction

  // Offer one byte until it is taken; push stays high for a following item.
  task automatic send_byte(input logic [7:0] c, input bit typed, input dec_item_t want,
                           output bit ended);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_byte <= c;
    @(posedge clk);
    while (full) @(posedge clk);
    decode_byte(c);
    ended = 1'b0;
    if (typed) decoded_q.push_back(want);
    foreach (step_items[i]) begin
      if (step_items[i].is_st) ended = 1'b1;
      if (!typed) decoded_q.push_back(step_items[i]);
    end
    @(negedge clk);
  endtask

  // Let all results drain and the pipeline settle, then write the capacity.
  task automatic write_capacity(input logic [CAP_W-1:0] v);
    push <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cap_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver side: random pops, plus one long hold-off when asked.
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expected item.
  always @(posedge clk) begin
    dec_item_t got;
    dec_item_t want;
    if (!rst && pop && !empty) begin
      got.data = out_byte;
      got.is_st = is_status;
      got.st = status;
      got.last = last_of_run;
      if (decoded_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item: byte %02h is_status %0b status %0d last %0b",
                 $time, got.data, got.is_st, got.st, got.last);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          $display("%0t: expected byte %02h is_status %0b status %0d last %0b, got byte %02h is_status %0b status %0d last %0b",
                   $time, want.data, want.is_st, want.st, want.last,
                   got.data, got.is_st, got.st, got.last);
        end
      end
    end
  end

  // Main stimulus.
  initial begin
    bit ended;
    int sent;
    logic [CAP_W-1:0] cap;
    rst = 1'b1;
    push = 1'b0;
    in_byte = 8'h00;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cap_reg = CAP_RESET;
    clear_value();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part: end bytes and errors in the prefix, extreme bytes,
    // a surrogate pair, a clean close and an early end.
    row("x", 1'b1, 8'h00, 1'b1, ST_NO_COLON);
    row(CH_END, 1'b1, 8'h00, 1'b1, ST_NO_COLON);
    row(CH_COLON);
    row(8'h0A);
    row(CH_END, 1'b1, 8'h00, 1'b1, ST_NO_QUOTE);
    row(CH_COLON);
    row(CH_QUOTE);
    row("A", 1'b1, "A", 1'b0, ST_OK);
    row(8'hFF);
    row(CH_BSLASH);
    row("u");
    row("D");
    row("8");
    row("3");
    row("D");
    row(CH_BSLASH);
    row("u");
    row("d");
    row("e");
    row("0");
    row("0");
    row(CH_QUOTE, 1'b1, 8'h00, 1'b1, ST_OK);
    row(CH_COLON);
    row(CH_QUOTE);
    row(CH_END, 1'b1, 8'h00, 1'b1, ST_EARLY_END);

    send_idle_pct = 6;
    recv_idle_pct = 84;
    foreach (dir_tab[i]) send_byte(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].want, ended);

    // Random part over several capacities and idling patterns.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: cap = 13'd1;
        1: cap = 13'd9;
        2: cap = 13'd4096;
        3: cap = 13'd3;
        4: cap = 13'd4095;
        default: cap = 13'd60;
      endcase
      write_capacity(cap);
      send_idle_pct = (p < 2) ? 6 : (p < 4) ? 84 : 0;
      recv_idle_pct = (p < 2) ? 84 : (p < 4) ? 6 : 0;
      // Stall the receiver for a long stretch so the block backs up.
      if (p == 4) long_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_value();
        while (text_q.size() > 0) begin
          send_byte(text_q.pop_front(), 1'b0, '0, ended);
          sent++;
          // Once the value has ended, the rest of its text is dropped.
          if (ended) text_q.delete();
        end
      end
    end

    push <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("json_string_value_decoder_top test passed");
    end else begin
      $display("json_string_value_decoder_top test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1200000;
    $display("json_string_value_decoder_top test failed");
    $finish;
  end

endmodule

[json_string_value_decoder_top.f]
src/jsv_pkg.sv
src/jsv_queue.sv
src/jsv_front.sv
src/jsv_back.sv
src/json_string_value_decoder_top.sv
sim/tb.sv
